FILE: src/eecq_pkg.sv
// Shared types and constants for the earliest-expiry consume queue.
`timescale 1ns / 1ps
`default_nettype none

package eecq_pkg;

    localparam int UNITS_W  = 16;
    localparam int LIFE_W   = 16;
    localparam int DAY_W    = 32;
    localparam int EXPIRY_W = 33;
    localparam int TOTAL_W  = 32;

    localparam logic [DAY_W-1:0]   DAY_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Operation broadcast along the cell chain.
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_SHIFT  = 2'd1;
    localparam cell_op_t OP_INSERT = 2'd2;
    localparam cell_op_t OP_DEC    = 2'd3;

    // One stored batch.
    typedef struct packed {
        logic                live;
        logic [EXPIRY_W-1:0] expiry;
        logic [UNITS_W-1:0]  units;
    } entry_t;

endpackage

`default_nettype wire

FILE: src/eecq_cell.sv
// One cell of the sorted batch chain: holds a single batch and trades with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module eecq_cell
    import eecq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cell_op_t op,
    input  wire entry_t   new_entry,
    input  wire entry_t   left_entry,
    input  wire logic     left_flag,
    input  wire entry_t   right_entry,
    output entry_t        entry,
    output logic          flag
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   own_flag;

    // The new batch belongs at or before this cell when the cell is empty or holds a
    // larger key; the flags are monotonic along the chain because it stays sorted.
    assign own_flag = !entry_reg.live ||
                      ({new_entry.expiry, new_entry.units} <
                       {entry_reg.expiry, entry_reg.units});
    assign flag = left_flag || own_flag;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (op)
            OP_HOLD:
            begin
                entry_next = entry_reg;
            end
            OP_SHIFT:
            begin
                entry_next = right_entry;
            end
            OP_INSERT:
            begin
                if (left_flag)
                begin
                    entry_next = left_entry;
                end
                else if (own_flag)
                begin
                    entry_next = new_entry;
                end
            end
            OP_DEC:
            begin
                entry_next.units = entry_reg.units - UNITS_W'(1);
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: src/earliest_expiry_consume_queue.sv
// Top level of the earliest-expiry consume queue built on a sorted chain of cells.
`timescale 1ns / 1ps
`default_nettype none

// Each request on the s_axis channel is one day tick, optionally carrying a new batch
// (unit count and shelf life). Each tick yields exactly one result on m_axis: whether a
// unit was consumed, the saturating running total, whether the store is now empty and
// whether the new batch was lost to a full store.
// Batches live in a chain of QUEUE_DEPTH cells kept sorted by expiry and then unit
// count, so the batch to consume from is always in the first cell. Expired batches form
// a prefix of the chain and are shifted out one per cycle before the next request is
// taken; a new batch is placed by every cell deciding locally whether to keep, take its
// left neighbour or take the new batch.
// A tick has two steps: the new batch, if any, is placed when the request is accepted,
// then a unit is taken from the first cell in the consume state, and the result is
// written to the output register as soon as that register is free. Each batch that has
// expired by the next day is shifted out before the next request is taken.
// Reset empties the chain and clears the day counter and the running total.
// When the receiver stalls, the result waits in the output register; one further request
// may still be accepted and placed, but its consumption waits until the register frees.

module earliest_expiry_consume_queue
    import eecq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [15:0] batch_units, [31:16] shelf_life
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // [0] unit_taken, [32:1] units_total,
                                            // [33] store_empty, [34] batch_dropped, rest 0
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [DAY_W-1:0]    day_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_inc;
    logic                dropped_reg;

    logic                out_valid_reg;
    logic                out_taken_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic                out_empty_reg;
    logic                out_dropped_reg;

    entry_t              cells [QUEUE_DEPTH];
    logic                flags [QUEUE_DEPTH];
    cell_op_t            op_sel;
    entry_t              new_entry;
    entry_t              empty_entry;

    logic [UNITS_W-1:0]  in_units;
    logic [LIFE_W-1:0]   in_life;
    logic                in_fire;
    logic                batch_valid;
    logic                chain_full;
    logic                head_expired;
    logic                out_free;
    logic                pop_fire;
    logic                head_last_unit;

    assign in_units = s_axis_tdata[UNITS_W-1:0];
    assign in_life  = s_axis_tdata[UNITS_W +: LIFE_W];

    assign empty_entry = '0;

    // Today's date is fixed until the next tick, so expired batches are removed while
    // waiting for the request; they always sit at the head of the sorted chain.
    assign head_expired = cells[0].live && (cells[0].expiry <= {1'b0, day_reg});
    assign chain_full   = cells[QUEUE_DEPTH-1].live;
    assign batch_valid  = (in_units != '0) && (in_life != '0);

    assign s_axis_tready = (state_reg == ST_IDLE) && !head_expired;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign out_free       = !out_valid_reg || m_axis_tready;
    assign pop_fire       = (state_reg == ST_POP) && out_free;
    assign head_last_unit = cells[0].units == UNITS_W'(1);

    assign new_entry.live   = 1'b1;
    assign new_entry.expiry = {1'b0, day_reg} + EXPIRY_W'(in_life);
    assign new_entry.units  = in_units;

    always_comb
    begin
        op_sel = OP_HOLD;
        if (state_reg == ST_IDLE)
        begin
            if (head_expired)
            begin
                op_sel = OP_SHIFT;
            end
            else if (in_fire && batch_valid && !chain_full)
            begin
                op_sel = OP_INSERT;
            end
        end
        else if (pop_fire && cells[0].live)
        begin
            // A batch down to its last unit leaves the chain; otherwise only the head counts down.
            op_sel = head_last_unit ? OP_SHIFT : OP_DEC;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            cell_op_t cell_op;
            entry_t   left_e;
            logic     left_f;
            entry_t   right_e;

            if (gi == 0)
            begin : g_first
                assign left_e  = empty_entry;
                assign left_f  = 1'b0;
                assign cell_op = op_sel;
            end
            else
            begin : g_rest
                assign left_e  = cells[gi-1];
                assign left_f  = flags[gi-1];
                assign cell_op = (op_sel == OP_DEC) ? OP_HOLD : op_sel;
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = empty_entry;
            end
            else
            begin : g_inner
                assign right_e = cells[gi+1];
            end

            eecq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (cell_op),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_flag   (left_f),
                .right_entry (right_e),
                .entry       (cells[gi]),
                .flag        (flags[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (pop_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign total_inc = (total_reg == TOTAL_MAX) ? total_reg : total_reg + TOTAL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            day_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop_fire)
            begin
                out_valid_reg <= 1'b1;
                if (day_reg != DAY_MAX)
                begin
                    day_reg <= day_reg + DAY_W'(1);
                end
                if (cells[0].live)
                begin
                    total_reg <= total_inc;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; the store is empty afterwards when the head was the only batch
    // and has just run out, or when there was no batch at all.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dropped_reg <= batch_valid && chain_full;
        end
        if (pop_fire)
        begin
            out_taken_reg   <= cells[0].live;
            out_total_reg   <= cells[0].live ? total_inc : total_reg;
            out_empty_reg   <= (cells[0].live && head_last_unit) ? !cells[1].live
                                                                 : !cells[0].live;
            out_dropped_reg <= dropped_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_dropped_reg, out_empty_reg, out_total_reg,
                            out_taken_reg};

    // The chain must stay sorted at its head, so the first cell is the one to consume.
    assert property (@(posedge clk) disable iff (!rst_n)
        cells[1].live |-> (cells[0].live &&
            ({cells[0].expiry, cells[0].units} <= {cells[1].expiry, cells[1].units})))
        else $error("batch chain out of order at its head");

    // An accepted request always moves on to consumption in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_POP))
        else $error("accepted request did not reach the consume step");

    // The running total never decreases.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= $past(total_reg))
        else $error("running total went backwards");

endmodule

`default_nettype wire

FILE: bench/eecq_day_checker.sv
// Checker that predicts the day report of the consume queue and compares it on the result channel.
`timescale 1ns / 1ps

module eecq_day_checker
    import eecq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] batch_units, [31:16] shelf_life
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // [0] unit_taken, [32:1] units_total,
                                             // [33] store_empty, [34] batch_dropped, rest 0
    output int               fail_count,
    output int               reports_due,
    output logic             shelf_bare,
    output int               units_seen,
    output int               drops_seen,
    output int               bare_days_seen
);

    typedef struct packed {
        logic               dropped;
        logic               empty;
        logic [TOTAL_W-1:0] total;
        logic               taken;
    } day_report_t;

    logic [EXPIRY_W-1:0] shelf_expiry [QUEUE_DEPTH];
    logic [UNITS_W-1:0]  shelf_units  [QUEUE_DEPTH];
    logic                shelf_live   [QUEUE_DEPTH];
    logic [DAY_W-1:0]    today;
    logic [TOTAL_W-1:0]  eaten_total;
    day_report_t         due_reports [$];

    // One day of the store: purge, place, consume from the earliest batch.
    task automatic advance_day(input logic [UNITS_W-1:0] units, input logic [LIFE_W-1:0] life,
                               output day_report_t rep);
        int   slot;
        int   best;
        logic any_live;
        slot     = -1;
        best     = -1;
        any_live = 1'b0;
        rep      = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (shelf_live[k] && shelf_expiry[k] <= {1'b0, today})
                shelf_live[k] = 1'b0;
        end
        if (units != '0 && life != '0)
        begin
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                if (slot < 0 && !shelf_live[k])
                    slot = k;
            end
            if (slot >= 0)
            begin
                shelf_expiry[slot] = {1'b0, today} + {{(EXPIRY_W-LIFE_W){1'b0}}, life};
                shelf_units[slot]  = units;
                shelf_live[slot]   = 1'b1;
            end
            else
                rep.dropped = 1'b1;
        end
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (shelf_live[k] && (best < 0 || shelf_expiry[k] < shelf_expiry[best] ||
                (shelf_expiry[k] == shelf_expiry[best] && shelf_units[k] < shelf_units[best])))
                best = k;
        end
        if (best >= 0)
        begin
            rep.taken = 1'b1;
            shelf_units[best] = shelf_units[best] - 1'b1;
            if (shelf_units[best] == '0)
                shelf_live[best] = 1'b0;
            if (eaten_total != TOTAL_MAX)
                eaten_total = eaten_total + 1'b1;
        end
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (shelf_live[k])
                any_live = 1'b1;
        end
        if (today != DAY_MAX)
            today = today + 1'b1;
        rep.total = eaten_total;
        rep.empty = !any_live;
    endtask

    task automatic compare_field(input string field, input logic [TOTAL_W-1:0] want,
                                 input logic [TOTAL_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        day_report_t want;
        day_report_t fresh;
        if (!rst_n)
        begin
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                shelf_live[k]   = 1'b0;
                shelf_expiry[k] = '0;
                shelf_units[k]  = '0;
            end
            today          = '0;
            eaten_total    = '0;
            fail_count     = 0;
            units_seen     = 0;
            drops_seen     = 0;
            bare_days_seen = 0;
            due_reports.delete();
            reports_due <= 0;
            shelf_bare  <= 1'b1;
        end
        else
        begin
            // The result leaving now always belongs to an earlier request.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_reports.size() == 0)
                begin
                    $display("%0t: report with no day tick waiting, expected none, actual %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    compare_field("unit_taken", want.taken, m_axis_tdata[0]);
                    compare_field("units_total", want.total, m_axis_tdata[32:1]);
                    compare_field("store_empty", want.empty, m_axis_tdata[33]);
                    compare_field("batch_dropped", want.dropped, m_axis_tdata[34]);
                    compare_field("padding", '0, m_axis_tdata[39:35]);
                    units_seen     += want.taken;
                    drops_seen     += want.dropped;
                    bare_days_seen += want.empty;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_day(s_axis_tdata[15:0], s_axis_tdata[31:16], fresh);
                due_reports.insert(due_reports.size(), fresh);
                shelf_bare <= fresh.empty;
            end
            reports_due <= due_reports.size();
        end
    end

endmodule

FILE: bench/earliest_expiry_consume_queue_tb.sv
// Testbench top for the earliest-expiry consume queue: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module earliest_expiry_consume_queue_tb;
    import eecq_pkg::*;

    localparam int QUEUE_DEPTH   = 32;
    localparam int TICK_TARGET   = 850;
    // A slow tick is stretched by purged batches and by stalls on both sides;
    // even a few thousand ticks stay well inside this.
    localparam int CYCLE_LIMIT   = 500000;
    // Worst case for one tick is a full purge of the chain plus its place and consume steps.
    localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [15:0] batch_units, [31:16] shelf_life
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [0] unit_taken, [32:1] units_total,
                                       // [33] store_empty, [34] batch_dropped, rest 0

    int   fail_count;
    int   reports_due;
    logic shelf_bare;
    int   units_seen;
    int   drops_seen;
    int   bare_days_seen;

    int cycle_count = 0;
    int ticks_sent  = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    earliest_expiry_consume_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    eecq_day_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) day_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .fail_count     (fail_count),
        .reports_due    (reports_due),
        .shelf_bare     (shelf_bare),
        .units_seen     (units_seen),
        .drops_seen     (drops_seen),
        .bare_days_seen (bare_days_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver switches at random between four behaviours: always ready, coin toss,
    // mostly ready or mostly stalled, so that back-pressure meets every phase of a tick.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= ($urandom_range(0, 9) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d reports outstanding.",
                     cycle_count, reports_due);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sends one day tick as a request. The sender works in bursts; at the start of each
    // burst it may drop tvalid for a random gap. This task only lowers tvalid on a gap,
    // never between two back-to-back requests, so it gets one assignment per edge.
    task automatic send_day(input logic [UNITS_W-1:0] units, input logic [LIFE_W-1:0] life);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {life, units};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // Holds the sender off until every report already requested has come back.
    task automatic hold_until_settled;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int kind;
        int n;
        int base;
        int pick;
        int total_fails;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty tick on an empty store, then both kinds of half batch,
        // which must store nothing and drop nothing.
        send_day(16'd0, 16'd0);
        send_day(16'd5, 16'd0);
        send_day(16'd0, 16'd7);
        // Largest unit count with a short life: it is consumed twice and then discarded
        // on the very day its expiry equals today.
        send_day(16'hFFFF, 16'd2);
        send_day(16'd0, 16'd0);
        send_day(16'd0, 16'd0);
        send_day(16'd0, 16'd0);
        // Longest shelf life; the single unit goes at once.
        send_day(16'd1, 16'hFFFF);
        send_day(16'h5555, 16'd1);
        send_day(16'd0, 16'd0);
        send_day(16'd1, 16'hAAAA);
        send_day(16'd1, 16'h5555);
        send_day(16'hAAAA, 16'd3);
        // Two batches with the same expiry and different counts: the smaller one goes first.
        send_day(16'd6, 16'd10);
        send_day(16'd5, 16'd9);
        // A batch with a larger count that expires before that pair goes first.
        send_day(16'd9, 16'd7);
        // An earlier expiry beats a smaller count.
        send_day(16'd2, 16'd20);
        send_day(16'd50, 16'd3);
        send_day(16'd0, 16'd0);
        while (!shelf_bare)
            send_day(16'd0, 16'd0);
        hold_until_settled();

        // Random part, in phases of different character.
        while (ticks_sent < TICK_TARGET)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 8)
            begin
                // Ordinary traffic: small batches mixed with empty and half ticks.
                n = $urandom_range(5, 40);
                repeat (n)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        send_day(16'($urandom_range(1, 8)), 16'($urandom_range(1, 30)));
                    else if (pick < 8)
                        send_day(16'd0, 16'd0);
                    else if (pick == 8)
                        send_day(16'($urandom_range(1, 8)), 16'd0);
                    else
                        send_day(16'd0, 16'($urandom_range(1, 30)));
                end
            end
            else if (kind < 11)
            begin
                // Fill the store with long-lived batches until new ones are dropped.
                n = $urandom_range(34, 40);
                repeat (n)
                    send_day(16'($urandom_range(20, 60)), 16'($urandom_range(60, 150)));
            end
            else if (kind < 14)
            begin
                while (!shelf_bare)
                    send_day(16'd0, 16'd0);
            end
            else if (kind < 17)
            begin
                // Batches arriving on consecutive days that all share one expiry day,
                // with small counts so that equal counts come up often.
                base = $urandom_range(8, 30);
                n    = $urandom_range(2, 8);
                for (int i = 0; i < n; i++)
                    send_day(16'($urandom_range(1, 4)), 16'(base - i));
            end
            else
            begin
                // Full-range values, kept so that nothing lives long with many units.
                n = $urandom_range(3, 12);
                repeat (n)
                begin
                    pick = $urandom_range(0, 3);
                    if (pick == 0)
                        send_day(16'($urandom), 16'($urandom_range(1, 4)));
                    else if (pick == 1)
                        send_day(16'($urandom_range(1, 3)), 16'($urandom));
                    else if (pick == 2)
                        send_day(16'($urandom), 16'd0);
                    else
                        send_day(16'd0, 16'($urandom));
                end
            end
            if ($urandom_range(0, 5) == 0)
                hold_until_settled();
        end

        // The store is run dry with empty ticks before the end; each tick is settled
        // first so that the emptiness seen is that of the latest day.
        hold_until_settled();
        while (!shelf_bare)
        begin
            send_day(16'd0, 16'd0);
            hold_until_settled();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        total_fails = fail_count + reports_due;
        $display("Sent %0d day ticks; %0d units were taken and %0d batches lost to a full store.",
                 ticks_sent, units_seen, drops_seen);
        $display("%0d reports showed an empty store; %0d mismatches.", bare_days_seen, total_fails);
        if (total_fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
